### sv/two_pool_first_fit_allocator_defines.svh
// ---------------------------------------------------------------------------
// two_pool_first_fit_allocator_defines
// Assertion macros for the two-pool allocator, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define TWO_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TPFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tpfa_pkg.sv
// ---------------------------------------------------------------------------
// tpfa_pkg
// Shared types and constants of the two-pool first-fit allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpfa_pkg;

  localparam int AW          = 13;
  localparam int REQ_W       = 16;
  localparam int THR_W       = 12;
  localparam int NEED_W      = REQ_W + 1;
  localparam int FS_W        = 8;     // slots checked per cycle in the free-slot search

  localparam logic [THR_W-1:0] THR_RESET = 12'd50;

  localparam int ARENA_BYTES_DEF = 5000;
  localparam int SMALL_POOL_DEF  = 2499;
  localparam int HEADER_DEF      = 32;
  localparam int MAX_SEG_DEF     = 256;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_ROOM      = 3'd1,
    ST_SIZE_EQ      = 3'd2,
    ST_OUT_OF_ARENA = 3'd3,
    ST_NOT_START    = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RS_HEAD,
    RS_NEXT,
    RS_SCAN,
    RS_SUCC
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_A_WALK,
    S_A_SLOT,
    S_A_WT,
    S_A_WC,
    S_F_SCAN,
    S_P_SCAN,
    S_N_ISSUE,
    S_N_CHK,
    S_F_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    ld_req;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    scan_run;
    logic    ld_ent_rd;
    logic    fs_clr;
    logic    fs_step;
    logic    wr_tail;
    logic    wr_cur;
    logic    merge_pred;
    logic    merge_succ;
    logic    wr_ent;
    logic    res_ld;
    status_t res_status;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic eq_thr;
    logic bad_addr;
    logic rv;
    logic last;
    logic fit;
    logic chain_end;
    logic fmatch;
    logic rd_free;
    logic pmatch;
    logic succ_ok;
    logic fs_found;
    logic fs_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### sv/tpfa_ctrl.sv
// ---------------------------------------------------------------------------
// tpfa_ctrl
// Sequencer: steps one request through walk, slot search, table scans,
// merges and write-back, then hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tpfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tpfa_pkg::sts_t sts,
  output tpfa_pkg::cmd_t      cmd
);

  tpfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpfa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tpfa_pkg::S_DEC;
      end
      tpfa_pkg::S_DEC: begin
        if (!sts.is_free_op) begin
          state_nxt = sts.eq_thr ? tpfa_pkg::S_RESP : tpfa_pkg::S_A_WALK;
        end else begin
          state_nxt = sts.bad_addr ? tpfa_pkg::S_RESP : tpfa_pkg::S_F_SCAN;
        end
      end
      tpfa_pkg::S_A_WALK: begin
        if (sts.fit) state_nxt = tpfa_pkg::S_A_SLOT;
        else if (sts.chain_end) state_nxt = tpfa_pkg::S_RESP;
      end
      tpfa_pkg::S_A_SLOT: begin
        if (sts.fs_found) state_nxt = tpfa_pkg::S_A_WT;
        else if (sts.fs_last) state_nxt = tpfa_pkg::S_RESP;
      end
      tpfa_pkg::S_A_WT: state_nxt = tpfa_pkg::S_A_WC;
      tpfa_pkg::S_A_WC: state_nxt = tpfa_pkg::S_RESP;
      tpfa_pkg::S_F_SCAN: begin
        if (sts.rv && sts.fmatch) begin
          state_nxt = sts.rd_free ? tpfa_pkg::S_RESP : tpfa_pkg::S_P_SCAN;
        end else if (sts.rv && sts.last) begin
          state_nxt = tpfa_pkg::S_RESP;
        end
      end
      tpfa_pkg::S_P_SCAN: begin
        if (sts.rv && (sts.pmatch || sts.last)) state_nxt = tpfa_pkg::S_N_ISSUE;
      end
      tpfa_pkg::S_N_ISSUE: begin
        state_nxt = sts.succ_ok ? tpfa_pkg::S_N_CHK : tpfa_pkg::S_F_WR;
      end
      tpfa_pkg::S_N_CHK: state_nxt = tpfa_pkg::S_F_WR;
      tpfa_pkg::S_F_WR:  state_nxt = tpfa_pkg::S_RESP;
      tpfa_pkg::S_RESP: begin
        if (!sts.out_busy) state_nxt = tpfa_pkg::S_IDLE;
      end
      default: state_nxt = tpfa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = tpfa_pkg::RS_SCAN;
    cmd.res_status = tpfa_pkg::ST_OK;
    in_stall       = (state_r != tpfa_pkg::S_IDLE);
    case (state_r)
      tpfa_pkg::S_IDLE: begin
        cmd.ld_req = in_valid;
      end
      tpfa_pkg::S_DEC: begin
        if (!sts.is_free_op) begin
          if (sts.eq_thr) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = tpfa_pkg::ST_SIZE_EQ;
          end else begin
            cmd.rd_sel = tpfa_pkg::RS_HEAD;
          end
        end else if (sts.bad_addr) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = tpfa_pkg::ST_OUT_OF_ARENA;
        end else begin
          cmd.scan_clr = 1'b1;
        end
      end
      tpfa_pkg::S_A_WALK: begin
        cmd.rd_sel = tpfa_pkg::RS_NEXT;
        if (sts.fit) begin
          cmd.ld_ent_rd = 1'b1;
          cmd.fs_clr    = 1'b1;
        end else if (sts.chain_end) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = tpfa_pkg::ST_NO_ROOM;
        end
      end
      tpfa_pkg::S_A_SLOT: begin
        cmd.fs_step = 1'b1;
        if (!sts.fs_found && sts.fs_last) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = tpfa_pkg::ST_NO_ROOM;
        end
      end
      tpfa_pkg::S_A_WT: cmd.wr_tail = 1'b1;
      tpfa_pkg::S_A_WC: begin
        cmd.wr_cur = 1'b1;
        cmd.res_ld = 1'b1;
      end
      tpfa_pkg::S_F_SCAN: begin
        if (sts.rv && sts.fmatch) begin
          cmd.ld_ent_rd = 1'b1;
          if (sts.rd_free) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = tpfa_pkg::ST_ALREADY_FREE;
          end else begin
            cmd.scan_clr = 1'b1;
          end
        end else if (sts.rv && sts.last) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = tpfa_pkg::ST_NOT_START;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      tpfa_pkg::S_P_SCAN: begin
        cmd.scan_run   = 1'b1;
        cmd.merge_pred = sts.rv && sts.pmatch && sts.rd_free;
      end
      tpfa_pkg::S_N_ISSUE: cmd.rd_sel = tpfa_pkg::RS_SUCC;
      tpfa_pkg::S_N_CHK:   cmd.merge_succ = sts.rd_free;
      tpfa_pkg::S_F_WR: begin
        cmd.wr_ent = 1'b1;
        cmd.res_ld = 1'b1;
      end
      tpfa_pkg::S_RESP: cmd.out_ld = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/tpfa_dp.sv
// ---------------------------------------------------------------------------
// tpfa_dp
// Datapath: segment table memory, slot valid bits, pool heads, scan and
// slot-search counters, working entry, result and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tpfa_dp #(
  parameter int ARENA_BYTES      = tpfa_pkg::ARENA_BYTES_DEF,
  parameter int SMALL_POOL_BYTES = tpfa_pkg::SMALL_POOL_DEF,
  parameter int HEADER_BYTES     = tpfa_pkg::HEADER_DEF,
  parameter int MAX_SEGMENTS     = tpfa_pkg::MAX_SEG_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tpfa_pkg::THR_W-1:0] cfg_wr_data,
  input  wire logic                       in_opcode,
  input  wire logic [tpfa_pkg::REQ_W-1:0] in_req_size,
  input  wire logic [tpfa_pkg::AW-1:0]    in_block_address,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_success,
  output logic [tpfa_pkg::AW-1:0]         out_payload_address,
  output logic [2:0]                      out_status,
  input  wire tpfa_pkg::cmd_t             cmd,
  output tpfa_pkg::sts_t                  sts
);

  localparam int AW  = tpfa_pkg::AW;
  localparam int SW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int FW  = $clog2(MAX_SEGMENTS + tpfa_pkg::FS_W) + 1;
  localparam int BIG_RAW = ARENA_BYTES - SMALL_POOL_BYTES - 2 * HEADER_BYTES - 2;
  localparam int BIG     = (BIG_RAW > 0) ? BIG_RAW : 0;

  typedef struct packed {
    logic [AW-1:0] hdr;
    logic [AW-1:0] size;
    logic          free;
    logic [SW-1:0] next;
  } seg_t;

  localparam seg_t HEAD0 = '{hdr: '0, size: AW'(SMALL_POOL_BYTES), free: 1'b1, next: SW'(0)};
  localparam seg_t HEAD1 = '{hdr: AW'(SMALL_POOL_BYTES + HEADER_BYTES), size: AW'(BIG),
                             free: 1'b1, next: SW'(1)};

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_q;
  seg_t rdata;

  logic [tpfa_pkg::THR_W-1:0] thr_r;
  logic                       op_r;
  logic [tpfa_pkg::REQ_W-1:0] req_r;
  logic [AW-1:0]              addr_r;
  logic [MAX_SEGMENTS-1:0]    inuse_r;
  logic [1:0]                 hw_r;     // head slot has been written
  logic [SW-1:0]              rd_idx_r;
  logic                       rv_r;
  logic [CW-1:0]              cnt_r;
  logic [FW-1:0]              fs_base_r;
  logic [SW-1:0]              nslot_r;
  logic [SW-1:0]              idx_r;
  seg_t                       ent_r;
  tpfa_pkg::status_t          res_status_r;
  logic [AW-1:0]              res_pay_r;
  logic                       out_valid_r;
  logic                       out_success_r;
  logic [AW-1:0]              out_pay_r;
  logic [2:0]                 out_status_r;

  logic [SW-1:0]               raddr;
  logic [SW-1:0]               head_idx;
  logic [tpfa_pkg::NEED_W-1:0] need;
  logic                        issue;
  logic                        we;
  logic [SW-1:0]               waddr;
  seg_t                        wdata;
  logic                        fs_found;
  logic [SW-1:0]               fs_idx;
  logic [FW-1:0]               cand;
  seg_t                        tail;
  logic [SW-1:0]               succ;

  assign need     = {1'b0, req_r} + tpfa_pkg::NEED_W'(HEADER_BYTES);
  assign head_idx = (req_r < {4'd0, thr_r}) ? SW'(0) : SW'(1);
  assign issue    = cmd.scan_run && (cnt_r < CW'(MAX_SEGMENTS));
  assign succ     = ent_r.next;

  always_comb begin
    case (cmd.rd_sel)
      tpfa_pkg::RS_HEAD: raddr = head_idx;
      tpfa_pkg::RS_NEXT: raddr = rdata.next;
      tpfa_pkg::RS_SUCC: raddr = succ;
      default:           raddr = cnt_r[SW-1:0];
    endcase
  end

  // unwritten heads read as their reset contents
  always_comb begin
    rdata = rd_q;
    if (rd_idx_r < SW'(2) && !hw_r[rd_idx_r[0]]) begin
      rdata = rd_idx_r[0] ? HEAD1 : HEAD0;
    end
  end

  // free-slot search, FS_W slots per cycle
  always_comb begin
    fs_found = 1'b0;
    fs_idx   = '0;
    cand     = '0;
    for (int k = 0; k < tpfa_pkg::FS_W; k++) begin
      cand = fs_base_r + FW'(k);
      if (!fs_found && cand < FW'(MAX_SEGMENTS) && !inuse_r[cand[SW-1:0]]) begin
        fs_found = 1'b1;
        fs_idx   = cand[SW-1:0];
      end
    end
  end

  always_comb begin
    tail.hdr  = ent_r.hdr + need[AW-1:0];
    tail.size = ent_r.size - need[AW-1:0];
    tail.free = 1'b1;
    tail.next = (ent_r.next == idx_r) ? nslot_r : ent_r.next;
  end

  always_comb begin
    we    = cmd.wr_tail || cmd.wr_cur || cmd.wr_ent;
    waddr = idx_r;
    wdata = ent_r;
    if (cmd.wr_tail) begin
      waddr = nslot_r;
      wdata = tail;
    end else if (cmd.wr_cur) begin
      wdata.size = req_r[AW-1:0];
      wdata.free = 1'b0;
      wdata.next = nslot_r;
    end else begin
      wdata.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_comb begin
    sts.is_free_op = (op_r == tpfa_pkg::OP_FREE);
    sts.eq_thr     = (req_r == {4'd0, thr_r});
    sts.bad_addr   = (addr_r < AW'(HEADER_BYTES)) || (addr_r >= AW'(ARENA_BYTES));
    sts.rv         = rv_r;
    sts.last       = (rd_idx_r == SW'(MAX_SEGMENTS - 1));
    sts.fit        = rdata.free && ({4'd0, rdata.size} >= need);
    sts.chain_end  = (rdata.next == rd_idx_r);
    sts.fmatch     = inuse_r[rd_idx_r] &&
                     (({1'b0, rdata.hdr} + (AW + 1)'(HEADER_BYTES)) == {1'b0, addr_r});
    sts.rd_free    = rdata.free;
    sts.pmatch     = (rd_idx_r != idx_r) && inuse_r[rd_idx_r] && (rdata.next == idx_r);
    sts.succ_ok    = (succ != idx_r) && inuse_r[succ];
    sts.fs_found   = fs_found;
    sts.fs_last    = (32'(fs_base_r) + tpfa_pkg::FS_W >= MAX_SEGMENTS);
    sts.out_busy   = out_valid_r && out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= tpfa_pkg::THR_RESET;
      inuse_r     <= MAX_SEGMENTS'(3);
      hw_r        <= '0;
      rv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (we && waddr < SW'(2)) hw_r[waddr[0]] <= 1'b1;
      if (cmd.wr_tail) inuse_r[nslot_r] <= 1'b1;
      if (cmd.merge_pred) inuse_r[idx_r] <= 1'b0;
      if (cmd.merge_succ) inuse_r[rd_idx_r] <= 1'b0;
      if (cmd.scan_clr) begin
        cnt_r <= '0;
        rv_r  <= 1'b0;
      end else begin
        rv_r <= issue;
        if (issue) cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= raddr;
    if (cmd.ld_req) begin
      op_r   <= in_opcode;
      req_r  <= in_req_size;
      addr_r <= in_block_address;
    end
    if (cmd.fs_clr) fs_base_r <= '0;
    else if (cmd.fs_step) begin
      if (fs_found) nslot_r <= fs_idx;
      fs_base_r <= fs_base_r + FW'(tpfa_pkg::FS_W);
    end
    if (cmd.ld_ent_rd) begin
      ent_r <= rdata;
      idx_r <= rd_idx_r;
    end else if (cmd.merge_pred) begin
      ent_r.hdr  <= rdata.hdr;
      ent_r.size <= rdata.size + ent_r.size + AW'(HEADER_BYTES);
      ent_r.next <= (ent_r.next == idx_r) ? rd_idx_r : ent_r.next;
      idx_r      <= rd_idx_r;
    end else if (cmd.merge_succ) begin
      ent_r.size <= ent_r.size + rdata.size + AW'(HEADER_BYTES);
      ent_r.next <= (rdata.next == rd_idx_r) ? idx_r : rdata.next;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_pay_r    <= (cmd.wr_cur && cmd.res_status == tpfa_pkg::ST_OK) ?
                      ent_r.hdr + AW'(HEADER_BYTES) : '0;
    end
    if (cmd.out_ld) begin
      out_success_r <= (res_status_r == tpfa_pkg::ST_OK);
      out_pay_r     <= res_pay_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_success         = out_success_r;
  assign out_payload_address = out_pay_r;
  assign out_status          = out_status_r;

endmodule

`default_nettype wire

### sv/two_pool_first_fit_allocator.sv
// ---------------------------------------------------------------------------
// two_pool_first_fit_allocator
// First-fit segment allocator over a byte arena split into two pools.
// ---------------------------------------------------------------------------
// One request is handled at a time. An allocate walks its pool's chain
// segment by segment, then searches the table for a spare slot, 8 slots at
// a time; an allocate that finds no fit answers once its walk reaches the
// chain's end. A free scans the segment table through the table memory's
// single read port twice (owner, then predecessor), each scan stopping at
// its match. Early rejects go straight from decode to the response. The
// next request is taken while the previous result waits in the output
// register.
`default_nettype none
`include "two_pool_first_fit_allocator_defines.svh"

module two_pool_first_fit_allocator #(
  parameter int ARENA_BYTES      = tpfa_pkg::ARENA_BYTES_DEF,
  parameter int SMALL_POOL_BYTES = tpfa_pkg::SMALL_POOL_DEF,
  parameter int HEADER_BYTES     = tpfa_pkg::HEADER_DEF,
  parameter int MAX_SEGMENTS     = tpfa_pkg::MAX_SEG_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tpfa_pkg::THR_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_opcode,
  input  wire logic [tpfa_pkg::REQ_W-1:0] in_req_size,
  input  wire logic [tpfa_pkg::AW-1:0]    in_block_address,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_success,
  output logic [tpfa_pkg::AW-1:0]         out_payload_address,
  output logic [2:0]                      out_status
);

  tpfa_pkg::cmd_t cmd;
  tpfa_pkg::sts_t sts;
  logic           out_ok;
  logic           out_addr_nz;

  tpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpfa_dp #(
    .ARENA_BYTES      (ARENA_BYTES),
    .SMALL_POOL_BYTES (SMALL_POOL_BYTES),
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_SEGMENTS     (MAX_SEGMENTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_opcode           (in_opcode),
    .in_req_size         (in_req_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_success         (out_success),
    .out_payload_address (out_payload_address),
    .out_status          (out_status),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  assign out_ok      = (out_status == tpfa_pkg::ST_OK);
  assign out_addr_nz = (out_payload_address != '0);

  `TPFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not go busy")
  `TPFA_ASSERT_NOW(a_success_code, out_valid, out_success == out_ok, "success disagrees with status")
  `TPFA_ASSERT_NOW(a_addr_on_success, out_valid && out_addr_nz, out_success, "address on failed beat")

endmodule

`default_nettype wire

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for two_pool_first_fit_allocator.
// ---------------------------------------------------------------------------
// An in-bench model of both segment chains predicts every response. Directed
// beats cover the pool split, the threshold tie, zero-size tails, the arena
// bounds, non-start and double frees. Random phases then run over several
// thresholds with sender gaps, receiver stalls and one long receiver hold-off.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARENA  = 5000;
  localparam int SMALL  = 2499;
  localparam int HDR    = 32;
  localparam int NSEG   = 256;
  localparam int LIMIT  = 1_500_000;
  localparam int HOLD_CYCLES = 3000;

  typedef enum logic [1:0] {K_ALLOC, K_FREE_LIVE, K_FREE_ADDR} kind_t;

  typedef struct {
    kind_t                      kind;
    logic [tpfa_pkg::REQ_W-1:0] size;
    logic [tpfa_pkg::AW-1:0]    addr;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [tpfa_pkg::AW-1:0] addr;
    tpfa_pkg::status_t       st;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [tpfa_pkg::THR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = tpfa_pkg::OP_ALLOC;
  logic [tpfa_pkg::REQ_W-1:0] in_req_size = '0;
  logic [tpfa_pkg::AW-1:0] in_block_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_success;
  logic [tpfa_pkg::AW-1:0] out_payload_address;
  logic [2:0] out_status;

  two_pool_first_fit_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_req_size(in_req_size), .in_block_address(in_block_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_success(out_success),
    .out_payload_address(out_payload_address), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // segment chain model
  int unsigned seg_hdr [NSEG];
  int unsigned seg_size[NSEG];
  int unsigned seg_next[NSEG];
  bit          seg_free[NSEG];
  bit          seg_used[NSEG];
  int unsigned thr = tpfa_pkg::THR_RESET;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [tpfa_pkg::AW-1:0] freed_addrs[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  bit hold_go = 1'b0;

  task automatic model_alloc(input int unsigned req, output rsp_t r);
    int unsigned cur, need, ns;
    int e;
    r = '{1'b0, '0, tpfa_pkg::ST_NO_ROOM};
    if (req == thr) begin
      r.st = tpfa_pkg::ST_SIZE_EQ;
      return;
    end
    cur = (req < thr) ? 0 : 1;
    need = req + HDR;
    for (int steps = 0; steps < NSEG; steps++) begin
      if (seg_free[cur] && seg_size[cur] >= need) begin
        e = -1;
        for (int i = 0; i < NSEG; i++)
          if (!seg_used[i] && e < 0) e = i;
        if (e < 0) return;
        ns = e;
        seg_used[ns] = 1'b1;
        seg_hdr[ns]  = seg_hdr[cur] + need;
        seg_size[ns] = seg_size[cur] - need;
        seg_free[ns] = 1'b1;
        seg_next[ns] = (seg_next[cur] == cur) ? ns : seg_next[cur];
        seg_next[cur] = ns;
        seg_size[cur] = req;
        seg_free[cur] = 1'b0;
        r = '{1'b1, tpfa_pkg::AW'(seg_hdr[cur] + HDR), tpfa_pkg::ST_OK};
        return;
      end
      if (seg_next[cur] == cur || seg_next[cur] >= NSEG) return;
      cur = seg_next[cur];
    end
  endtask

  task automatic model_free(input int unsigned addr, output rsp_t r);
    int idx, n;
    r = '{1'b0, '0, tpfa_pkg::ST_OUT_OF_ARENA};
    if (addr < HDR || addr >= ARENA) return;
    idx = -1;
    for (int i = 0; i < NSEG; i++)
      if (idx < 0 && seg_used[i] && seg_hdr[i] + HDR == addr) idx = i;
    if (idx < 0) begin
      r.st = tpfa_pkg::ST_NOT_START;
      return;
    end
    if (seg_free[idx]) begin
      r.st = tpfa_pkg::ST_ALREADY_FREE;
      return;
    end
    seg_free[idx] = 1'b1;
    // fold into a free predecessor first
    for (int i = 0; i < NSEG; i++) begin
      if (i != idx && seg_used[i] && seg_next[i] == idx) begin
        if (seg_free[i]) begin
          seg_size[i] += seg_size[idx] + HDR;
          seg_next[i] = (seg_next[idx] == idx) ? i : seg_next[idx];
          seg_used[idx] = 1'b0;
          idx = i;
        end
        break;
      end
    end
    n = seg_next[idx];
    if (n != idx && n < NSEG && seg_used[n] && seg_free[n]) begin
      seg_size[idx] += seg_size[n] + HDR;
      seg_next[idx] = (seg_next[n] == n) ? idx : seg_next[n];
      seg_used[n] = 1'b0;
    end
    r = '{1'b1, '0, tpfa_pkg::ST_OK};
  endtask

  // live frees are resolved against the model when the beat is presented
  function automatic logic [tpfa_pkg::AW-1:0] pick_live();
    int live[$];
    for (int i = 0; i < NSEG; i++)
      if (seg_used[i] && !seg_free[i]) live.push_back(i);
    if (live.size() == 0) return tpfa_pkg::AW'($urandom_range(HDR, ARENA - 1));
    return tpfa_pkg::AW'(seg_hdr[live[$urandom_range(live.size() - 1)]] + HDR);
  endfunction

  // input driver
  always @(posedge clk) begin
    req_t q;
    rsp_t r;
    bit go;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_opcode == tpfa_pkg::OP_ALLOC) model_alloc(in_req_size, r);
        else begin
          model_free(in_block_address, r);
          if (r.ok) freed_addrs.push_back(in_block_address);
        end
        expected_rsps.push_back(r);
      end
      if (!in_valid || !in_stall) begin
        go = pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct;
        in_valid <= go;
        if (go) begin
          q = pending_reqs.pop_front();
          in_opcode <= (q.kind == K_ALLOC) ? tpfa_pkg::OP_ALLOC : tpfa_pkg::OP_FREE;
          in_req_size <= q.size;
          in_block_address <= (q.kind == K_FREE_LIVE) ? pick_live() : q.addr;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected beat success=%0d addr=%0d status=%0d", $time,
                   out_success, out_payload_address, out_status);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_success !== e.ok) begin
            $display("%0t: success exp %0d got %0d", $time, e.ok, out_success);
            errors++;
          end
          if (out_payload_address !== e.addr) begin
            $display("%0t: payload_address exp %0d got %0d", $time, e.addr,
                     out_payload_address);
            errors++;
          end
          if (out_status !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, out_status);
            errors++;
          end
        end
      end
      out_stall <= (hold_cnt > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (hold_go) begin
      hold_cnt <= HOLD_CYCLES;
      hold_go <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push(input kind_t k, input int unsigned sz, input int unsigned a);
    pending_reqs.push_back('{k, tpfa_pkg::REQ_W'(sz), tpfa_pkg::AW'(a)});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0 || hold_cnt > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_thr(input int unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tpfa_pkg::THR_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr = v;
  endtask

  task automatic random_phase(input int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 60) begin
        p = $urandom_range(99);
        if (p < 45)      push(K_ALLOC, $urandom_range(63), 0);
        else if (p < 70) push(K_ALLOC, $urandom_range(400), 0);
        else if (p < 80) push(K_ALLOC, $urandom_range(2500), 0);
        else if (p < 85) push(K_ALLOC, thr, 0);
        else             push(K_ALLOC, $urandom_range(65535), 0);
      end else if (p < 88) push(K_FREE_LIVE, $urandom_range(65535), 0);
      else if (p < 94 && freed_addrs.size() > 0)
        push(K_FREE_ADDR, $urandom_range(65535),
             freed_addrs[$urandom_range(freed_addrs.size() - 1)]);
      else push(K_FREE_ADDR, $urandom_range(65535), $urandom_range(8191));
    end
  endtask

  initial begin
    seg_used[0] = 1'b1; seg_free[0] = 1'b1; seg_size[0] = SMALL;
    seg_used[1] = 1'b1; seg_free[1] = 1'b1; seg_hdr[1] = SMALL + HDR;
    seg_size[1] = ARENA - SMALL - 2 * HDR - 2; seg_next[1] = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, threshold at reset value
    push(K_ALLOC, 2467, 0);          // big pool, too large to fit
    push(K_ALLOC, 0, 0);
    push(K_FREE_ADDR, 0, 32);
    push(K_FREE_ADDR, 0, 32);        // double free
    push(K_ALLOC, 2403, 0);          // big pool, zero-size tail
    push(K_FREE_LIVE, 0, 0);
    push(K_ALLOC, 50, 0);            // tie with threshold
    push(K_ALLOC, 65535, 0);
    push(K_ALLOC, 49, 0);
    push(K_ALLOC, 51, 0);
    push(K_FREE_ADDR, 0, 0);
    push(K_FREE_ADDR, 0, 31);
    push(K_FREE_ADDR, 0, 4999);
    push(K_FREE_ADDR, 0, 5000);
    push(K_FREE_ADDR, 0, 8191);
    push(K_FREE_ADDR, 0, 33);        // inside a payload, not a start
    push(K_FREE_LIVE, 0, 0);
    push(K_FREE_LIVE, 0, 0);
    drain();

    // threshold zero: every request goes big, a zero-size request ties
    write_thr(0);
    push(K_ALLOC, 0, 0);
    push(K_ALLOC, 5, 0);
    push(K_FREE_LIVE, 0, 0);
    drain();

    write_thr(50);
    random_phase(75);
    drain();

    write_thr(4095);
    idle_pct = 73;
    random_phase(75);
    drain();

    write_thr(1);
    idle_pct = 0;
    stall_pct = 73;
    random_phase(75);
    drain();

    write_thr(200);
    idle_pct = 20;
    stall_pct = 20;
    random_phase(75);
    drain();

    // long receiver hold-off while the sender keeps offering beats
    write_thr(120);
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    random_phase(75);
    drain();

    write_thr(50);
    random_phase(75);
    drain();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/tpfa_pkg.sv
sv/tpfa_ctrl.sv
sv/tpfa_dp.sv
sv/two_pool_first_fit_allocator.sv
sim/tb.sv
